// ===== rtl/apq_pkg.sv =====
// ----------------------------------------------------------------------------
// apq_pkg: shared constants and types for the array min-priority queue
// Sizes of the entry store, the result status codes and the action codes.
// ----------------------------------------------------------------------------
`default_nettype none

package apq_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int VALUE_W     = 32;
    localparam int PRIO_W      = 7;
    localparam int ENTRY_W     = VALUE_W + PRIO_W;

    typedef enum logic [1:0] {
        ST_ENQUEUED = 2'd0,
        ST_FULL     = 2'd1,
        ST_DEQUEUED = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef enum logic {
        ACT_ENQUEUE = 1'b0,
        ACT_DEQUEUE = 1'b1
    } action_t;

endpackage

`default_nettype wire

// ===== rtl/apq_ram.sv =====
// ----------------------------------------------------------------------------
// apq_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module apq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/array_min_priority_queue.sv =====
// ----------------------------------------------------------------------------
// array_min_priority_queue: bounded min-priority queue on an unsorted array
// Enqueue appends at the tail; dequeue scans for the lowest priority number
// (earliest wins ties), returns it and shifts the tail down one slot.
// ----------------------------------------------------------------------------
// Enqueue and empty-dequeue go from accept to S_DONE, which loads the result
// registers once the output is free. Dequeue first scans the held entries (S_SCAN),
//   then shifts the entries above the winner down one slot (S_SHIFT), then S_DONE.
// One item at a time; the single RAM read port paces both scan and shift.
// rst_n (async, active low) empties the queue; entry storage is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module array_min_priority_queue (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input items
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // [31:0] item_value, [38:32] item_priority, [39] 0
    input  wire logic        s_axis_tuser,  // [0] action
    // result items
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [39:0] m_axis_tdata,  // [31:0] out_value, [38:32] out_priority, [39] 0
    output logic      [1:0]  m_axis_tuser   // [1:0] status
);

    localparam int IDX_W   = apq_pkg::IDX_W;
    localparam int CNT_W   = apq_pkg::CNT_W;
    localparam int VALUE_W = apq_pkg::VALUE_W;
    localparam int PRIO_W  = apq_pkg::PRIO_W;
    localparam int ENTRY_W = apq_pkg::ENTRY_W;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;     // entries held
    logic [CNT_W-1:0]      issue_reg, issue_next;     // next RAM read address
    logic                  chk_valid_reg, chk_valid_next; // read data in flight
    logic [IDX_W-1:0]      chk_idx_reg, chk_idx_next; // slot tag of read data
    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      slot_reg, slot_next;       // winning slot
    logic [VALUE_W-1:0]    best_value_reg, best_value_next;
    logic [PRIO_W-1:0]     best_prio_reg, best_prio_next;
    apq_pkg::status_t      status_reg, status_next;
    logic                  out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]    out_value_reg, out_value_next;
    logic [PRIO_W-1:0]     out_prio_reg, out_prio_next;
    apq_pkg::status_t      out_status_reg, out_status_next;

    // RAM port
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic [IDX_W-1:0]      ram_raddr;
    logic [ENTRY_W-1:0]    ram_rdata;

    logic [VALUE_W-1:0]    rd_value;
    logic [PRIO_W-1:0]     rd_prio;
    logic                  in_accept;
    logic                  out_free;

    assign rd_value = ram_rdata[VALUE_W-1:0];
    assign rd_prio  = ram_rdata[ENTRY_W-1:VALUE_W];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_prio_reg, out_value_reg};
    assign m_axis_tuser  = out_status_reg;

    // Entry store: value in the low bits, priority above it
    apq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (apq_pkg::QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        issue_next      = issue_reg;
        chk_valid_next  = 1'b0;
        chk_idx_next    = chk_idx_reg;
        found_next      = found_reg;
        slot_next       = slot_reg;
        best_value_next = best_value_reg;
        best_prio_next  = best_prio_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_value_next  = out_value_reg;
        out_prio_next   = out_prio_reg;
        out_status_next = out_status_reg;

        ram_we    = 1'b0;
        ram_waddr = count_reg[IDX_W-1:0];
        ram_wdata = {s_axis_tdata[38:32], s_axis_tdata[31:0]};
        ram_raddr = issue_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    best_value_next = '0;
                    best_prio_next  = '0;
                    state_next      = S_DONE;
                    if (s_axis_tuser == apq_pkg::ACT_ENQUEUE)
                    begin
                        if (count_reg >= CNT_W'(apq_pkg::QUEUE_DEPTH))
                        begin
                            status_next = apq_pkg::ST_FULL;
                        end
                        else
                        begin
                            ram_we      = 1'b1;
                            count_next  = count_reg + 1'b1;
                            status_next = apq_pkg::ST_ENQUEUED;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = apq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        status_next = apq_pkg::ST_DEQUEUED;
                        issue_next  = '0;
                        found_next  = 1'b0;
                        slot_next   = '0;
                        state_next  = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // read slot issue_reg; compare the slot read last cycle
                if (issue_reg < count_reg)
                begin
                    issue_next     = issue_reg + 1'b1;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = issue_reg[IDX_W-1:0];
                end
                if (chk_valid_reg && (!found_reg || rd_prio < best_prio_reg))
                begin
                    found_next      = 1'b1;
                    slot_next       = chk_idx_reg;
                    best_value_next = rd_value;
                    best_prio_next  = rd_prio;
                end
                if (issue_reg >= count_reg && !chk_valid_reg)
                begin
                    issue_next = CNT_W'(slot_reg) + 1'b1;
                    state_next = S_SHIFT;
                end
            end

            S_SHIFT:
            begin
                // read slot j+1, write it to slot j in the next cycle
                if (issue_reg < count_reg)
                begin
                    issue_next     = issue_reg + 1'b1;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = IDX_W'(issue_reg - 1'b1);
                end
                if (chk_valid_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = chk_idx_reg;
                    ram_wdata = ram_rdata;
                end
                if (issue_reg >= count_reg && !chk_valid_reg)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = best_value_reg;
                    out_prio_next   = best_prio_reg;
                    out_status_next = status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            issue_reg      <= '0;
            chk_valid_reg  <= 1'b0;
            chk_idx_reg    <= '0;
            found_reg      <= 1'b0;
            slot_reg       <= '0;
            status_reg     <= apq_pkg::ST_ENQUEUED;
            out_valid_reg  <= 1'b0;
            out_status_reg <= apq_pkg::ST_ENQUEUED;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            issue_reg      <= issue_next;
            chk_valid_reg  <= chk_valid_next;
            chk_idx_reg    <= chk_idx_next;
            found_reg      <= found_next;
            slot_reg       <= slot_next;
            status_reg     <= status_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        best_value_reg <= best_value_next;
        best_prio_reg  <= best_prio_next;
        out_value_reg  <= out_value_next;
        out_prio_reg   <= out_prio_next;
    end

endmodule

`default_nettype wire
